// ===== rtl/tsn_pkg.sv =====
// tsn_pkg: widths and the stage record for the triangle surface normal block
// no dependencies; used by tsn_front, tsn_cell and triangle_surface_normal
package tsn_pkg;

  localparam int CW   = 16;  // coordinate width, q8.8
  localparam int EW   = 17;  // edge vector width
  localparam int PW   = 34;  // edge product width
  localparam int XW   = 35;  // cross product component width
  localparam int MW   = 34;  // cross product magnitude width
  localparam int HW   = 17;  // half of the magnitude for the partial products
  localparam int QW   = 68;  // squared component width
  localparam int SW   = 70;  // squared length width
  localparam int TS   = 28;  // target shift, 2^28 = (2^14)^2
  localparam int RW   = 96;  // residual width
  localparam int AW   = 86;  // n * squared length accumulator width
  localparam int DW   = 101; // trial difference width, top bit is the sign
  localparam int NW   = 15;  // normal magnitude width, 0..16384
  localparam int OW   = 16;  // normal output width, q1.14

  typedef struct packed {
    logic                  vld;
    logic                  degen;
    logic [SW-1:0]         s;
    logic [2:0][RW-1:0]    r;
    logic [2:0][AW-1:0]    p;
    logic [2:0][NW-1:0]    n;
    logic [2:0]            neg;
  } cell_t;

endpackage

// ===== rtl/tsn_front.sv =====
// tsn_front: edges, cross product and squared length, seven register stages
// depends on tsn_pkg
module tsn_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  logic                                 in_vld,
  input  logic [2:0][tsn_pkg::CW-1:0]          lp,
  input  logic [2:0][tsn_pkg::CW-1:0]          cp,
  input  logic [2:0][tsn_pkg::CW-1:0]          rp,
  output tsn_pkg::cell_t                       dout
);

  logic [5:0] v;

  logic signed [tsn_pkg::EW-1:0] a [3];
  logic signed [tsn_pkg::EW-1:0] b [3];
  logic signed [tsn_pkg::PW-1:0] pr [6];
  logic signed [tsn_pkg::XW-1:0] x [3];
  logic [tsn_pkg::MW-1:0]        m [3];
  logic [2:0]                    neg4, neg5, neg6;
  logic [tsn_pkg::PW-1:0]        hh [3];
  logic [tsn_pkg::PW-1:0]        hl [3];
  logic [tsn_pkg::PW-1:0]        ll [3];
  logic [tsn_pkg::QW-1:0]        q [3];
  logic [tsn_pkg::SW-1:0]        ssum;

  assign ssum = tsn_pkg::SW'(q[0]) + tsn_pkg::SW'(q[1]) + tsn_pkg::SW'(q[2]);

  // v[k] marks the data held in register stage k+1
  always_ff @(posedge clk) begin
    if (rst) begin
      v        <= '0;
      dout.vld <= 1'b0;
    end else if (adv) begin
      v        <= {v[4:0], in_vld};
      dout.vld <= v[5];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        // edges
        a[i] <= $signed({lp[i][tsn_pkg::CW-1], lp[i]}) - $signed({cp[i][tsn_pkg::CW-1], cp[i]});
        b[i] <= $signed({rp[i][tsn_pkg::CW-1], rp[i]}) - $signed({cp[i][tsn_pkg::CW-1], cp[i]});
      end
      // cross product terms
      pr[0] <= a[1] * b[2];
      pr[1] <= a[2] * b[1];
      pr[2] <= a[2] * b[0];
      pr[3] <= a[0] * b[2];
      pr[4] <= a[0] * b[1];
      pr[5] <= a[1] * b[0];
      for (int i = 0; i < 3; i++) begin
        x[i]    <= tsn_pkg::XW'(pr[2*i]) - tsn_pkg::XW'(pr[2*i+1]);
        m[i]    <= x[i][tsn_pkg::XW-1] ? tsn_pkg::MW'(-x[i]) : tsn_pkg::MW'(x[i]);
        neg4[i] <= x[i][tsn_pkg::XW-1];
        // square as three 17x17 partial products
        hh[i]   <= m[i][tsn_pkg::MW-1:tsn_pkg::HW] * m[i][tsn_pkg::MW-1:tsn_pkg::HW];
        hl[i]   <= m[i][tsn_pkg::MW-1:tsn_pkg::HW] * m[i][tsn_pkg::HW-1:0];
        ll[i]   <= m[i][tsn_pkg::HW-1:0] * m[i][tsn_pkg::HW-1:0];
        q[i]    <= (tsn_pkg::QW'(hh[i]) << (2*tsn_pkg::HW))
                 + (tsn_pkg::QW'(hl[i]) << (tsn_pkg::HW+1))
                 + tsn_pkg::QW'(ll[i]);
        dout.r[i] <= tsn_pkg::RW'(q[i]) << tsn_pkg::TS;
      end
      neg5       <= neg4;
      neg6       <= neg5;
      dout.neg   <= neg6;
      dout.s     <= ssum;
      dout.degen <= (ssum == '0);
      dout.p     <= '0;
      dout.n     <= '0;
    end
  end

endmodule

// ===== rtl/tsn_cell.sv =====
// tsn_cell: decides one bit of the three normal magnitudes, one register stage
// depends on tsn_pkg
module tsn_cell #(
  parameter int K = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  tsn_pkg::cell_t din,
  output tsn_pkg::cell_t dout
);

  logic [2:0][tsn_pkg::DW-1:0] trial;
  logic [2:0]                  ok;

  // trying n + 2^k: residual drops by s*(2^(k+1) n + 2^(2k))
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i] = tsn_pkg::DW'(din.r[i])
               - (tsn_pkg::DW'(din.p[i]) << (K+1))
               - (tsn_pkg::DW'(din.s) << (2*K));
      ok[i]    = !trial[i][tsn_pkg::DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (adv) begin
      dout.vld <= din.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout.degen <= din.degen;
      dout.s     <= din.s;
      dout.neg   <= din.neg;
      for (int i = 0; i < 3; i++) begin
        if (ok[i]) begin
          dout.r[i] <= trial[i][tsn_pkg::RW-1:0];
          dout.p[i] <= din.p[i] + (tsn_pkg::AW'(din.s) << K);
          dout.n[i] <= din.n[i] | (tsn_pkg::NW'(1) << K);
        end else begin
          dout.r[i] <= din.r[i];
          dout.p[i] <= din.p[i];
          dout.n[i] <= din.n[i];
        end
      end
    end
  end

endmodule

// ===== rtl/triangle_surface_normal.sv =====
// triangle_surface_normal: unit face normal of a triangle, q8.8 in, q1.14 out
// pipeline: 7 front stages, 15 bit cells, 1 output register
// throughput one transfer per cycle; a stalled output holds the whole pipeline
// reset (rst, synchronous) clears the stage valid bits only
// depends on tsn_pkg, tsn_front, tsn_cell
module triangle_surface_normal (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [tsn_pkg::CW-1:0]    left_x,
  input  logic [tsn_pkg::CW-1:0]    left_y,
  input  logic [tsn_pkg::CW-1:0]    left_z,
  input  logic [tsn_pkg::CW-1:0]    center_x,
  input  logic [tsn_pkg::CW-1:0]    center_y,
  input  logic [tsn_pkg::CW-1:0]    center_z,
  input  logic [tsn_pkg::CW-1:0]    right_x,
  input  logic [tsn_pkg::CW-1:0]    right_y,
  input  logic [tsn_pkg::CW-1:0]    right_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [tsn_pkg::OW-1:0]    normal_x,
  output logic [tsn_pkg::OW-1:0]    normal_y,
  output logic [tsn_pkg::OW-1:0]    normal_z,
  output logic                      degenerate
);

  logic                             adv;
  tsn_pkg::cell_t                   ch [tsn_pkg::NW+1];
  logic [2:0][tsn_pkg::OW-1:0]      nrm;

  // whole pipeline moves unless a finished transfer is held at the output
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // edges, cross product, squared length and initial residual 2^28*c^2
  tsn_front u_front (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .in_vld (in_valid),
    .lp     ({left_z, left_y, left_x}),
    .cp     ({center_z, center_y, center_x}),
    .rp     ({right_z, right_y, right_x}),
    .dout   (ch[0])
  );

  // restoring square-root style search, msb first: cell g settles bit NW-1-g
  for (genvar g = 0; g < tsn_pkg::NW; g++) begin : g_cell
    tsn_cell #(.K(tsn_pkg::NW-1-g)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .din  (ch[g]),
      .dout (ch[g+1])
    );
  end

  // apply the sign of each cross component, zero everything when degenerate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ch[tsn_pkg::NW].degen) begin
        nrm[i] = '0;
      end else if (ch[tsn_pkg::NW].neg[i]) begin
        nrm[i] = -tsn_pkg::OW'(ch[tsn_pkg::NW].n[i]);
      end else begin
        nrm[i] = tsn_pkg::OW'(ch[tsn_pkg::NW].n[i]);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ch[tsn_pkg::NW].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      normal_x   <= nrm[0];
      normal_y   <= nrm[1];
      normal_z   <= nrm[2];
      degenerate <= ch[tsn_pkg::NW].degen;
    end
  end

  // a degenerate triangle gives a zero normal
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("degenerate transfer with nonzero normal");

  // a proper normal never has all components zero
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |-> normal_x != '0 || normal_y != '0 || normal_z != '0)
    else $error("zero normal without degenerate flag");

  // every component stays within unit range
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $signed(normal_x) <= 16384 && $signed(normal_x) >= -16384
               && $signed(normal_y) <= 16384 && $signed(normal_y) >= -16384
               && $signed(normal_z) <= 16384 && $signed(normal_z) >= -16384)
    else $error("normal component out of range");

endmodule
